[hdl/cbpg_pkg.sv]
`timescale 1ns / 1ps
package cbpg_pkg;

  localparam int unsigned QDepthDefault = 2;

  localparam logic [7:0]  ThrReset    = 8'd170;
  localparam logic [8:0]  BrightReset = 9'd256;
  localparam logic [24:0] ViewerReset = 25'd0;

  localparam logic [33:0] FarLimit  = 34'd262144;
  localparam logic [33:0] FadeStart = 34'd196608;
  localparam logic [13:0] LiftBase  = 14'd4864;
  localparam logic [15:0] RecipThree = 16'd43691;

  typedef enum logic [1:0] {
    CfgDensityThreshold = 2'd0,
    CfgBrightness       = 2'd1,
    CfgViewerHeight     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  density_threshold;
    logic [8:0]  brightness;
    logic [24:0] viewer_height_q8;
  } cfg_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] base_height;
    logic [15:0] pos_z;
    logic [33:0] dist_sq;
    logic [7:0]  density;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_x;
    logic [24:0] out_height_q8;
    logic [15:0] out_z;
    logic [31:0] color;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] z;
    logic [24:0] h_first;
    logic [24:0] h_second;
    logic [31:0] col_first;
    logic [31:0] col_second;
  } pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] scale_ch(logic [8:0] base, logic [8:0] br);
    logic [17:0] prod;
    prod = base * br;
    scale_ch = (prod[17:16] != 2'b00) ? 8'd255 : prod[15:8];
  endfunction

endpackage

[hdl/cbpg_front.sv]
`timescale 1ns / 1ps
module cbpg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbpg_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cbpg_pkg::in_item_t in_data_i,
  output logic              push_valid_o,
  output cbpg_pkg::pair_t   push_data_o,
  input  cbpg_pkg::q_stat_t q_stat_i
);
  import cbpg_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] z;
    logic [15:0] base;
    logic [13:0] lift;
    logic [13:0] up;
    logic [12:0] down;
    logic [31:0] col_top;
    logic [31:0] col_bot;
  } stage_t;

  logic        stage_valid_q, stage_valid_d;
  stage_t      stage_q, stage_d;
  logic        in_xfer, reject, load;
  logic [7:0]  v;
  logic [18:0] rem;
  logic [23:0] lift_prod;
  logic [7:0]  ex;
  logic [23:0] third_prod;
  logic [14:0] third;
  logic [23:0] alpha_prod;
  logic [7:0]  alpha;
  logic [8:0]  inv;
  logic [9:0]  ta_sum, tb_sum;
  logic [8:0]  ta_base, tb_base, ba_base, bb_base;
  logic [7:0]  ta, tb, ba, bb;
  logic [24:0] h, top, bottom, down_ext;

  assign v = in_data_i.density;
  assign in_stall_o = stage_valid_q && q_stat_i.full;
  assign in_xfer = in_valid_i && !in_stall_o;
  assign reject = (v < cfg_i.density_threshold) || (in_data_i.dist_sq > FarLimit);
  assign load = in_xfer && !reject;

  // lift from distance
  assign rem = FarLimit[18:0] - in_data_i.dist_sq[18:0];
  assign lift_prod = rem * 5'd23;

  // density excess over 3 by reciprocal
  assign ex = v - cfg_i.density_threshold;
  assign third_prod = ex * RecipThree;
  assign third = third_prod[23:9];

  assign alpha_prod = v * rem[15:0];
  assign alpha = (in_data_i.dist_sq <= FadeStart) ? v : alpha_prod[23:16];

  assign inv = 9'd256 - {1'b0, v};
  assign ta_sum = 10'd218 + {2'b00, inv[8:1]};
  assign tb_sum = 10'd178 + {3'b000, inv[8:2]};
  assign ta_base = (ta_sum > 10'd255) ? 9'd255 : ta_sum[8:0];
  assign tb_base = (tb_sum > 10'd255) ? 9'd255 : tb_sum[8:0];
  assign ba_base = 9'd164 + inv;
  assign bb_base = 9'd148 + {1'b0, inv[8:1]};
  assign ta = scale_ch(ta_base, cfg_i.brightness);
  assign tb = scale_ch(tb_base, cfg_i.brightness);
  assign ba = scale_ch(ba_base, cfg_i.brightness);
  assign bb = scale_ch(bb_base, cfg_i.brightness);

  always_comb begin
    stage_d = stage_q;
    stage_valid_d = stage_valid_q && q_stat_i.full;
    if (load) begin
      stage_valid_d   = 1'b1;
      stage_d.x       = in_data_i.pos_x;
      stage_d.z       = in_data_i.pos_z;
      stage_d.base    = in_data_i.base_height;
      stage_d.lift    = LiftBase + lift_prod[23:10];
      stage_d.up      = third[14:1];
      stage_d.down    = third[14:2];
      stage_d.col_top = {alpha, tb, ta, ta};
      stage_d.col_bot = {alpha, bb, ba, ba};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  // final heights and emission order
  assign h = {1'b0, stage_q.base, 8'h00} + {11'd0, stage_q.lift};
  assign top = h + {11'd0, stage_q.up};
  assign down_ext = {12'd0, stage_q.down};
  assign bottom = (h > down_ext) ? (h - down_ext) : 25'd0;

  assign push_valid_o = stage_valid_q;

  always_comb begin
    push_data_o.x = stage_q.x;
    push_data_o.z = stage_q.z;
    if (h < cfg_i.viewer_height_q8) begin
      push_data_o.h_first    = top;
      push_data_o.h_second   = bottom;
      push_data_o.col_first  = stage_q.col_top;
      push_data_o.col_second = stage_q.col_bot;
    end else begin
      push_data_o.h_first    = bottom;
      push_data_o.h_second   = top;
      push_data_o.col_first  = stage_q.col_bot;
      push_data_o.col_second = stage_q.col_top;
    end
  end

endmodule

[hdl/cbpg_queue.sv]
`timescale 1ns / 1ps
module cbpg_queue #(
  parameter int unsigned Depth = cbpg_pkg::QDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  cbpg_pkg::pair_t   push_data_i,
  input  logic              pop_i,
  output cbpg_pkg::pair_t   pop_data_o,
  output cbpg_pkg::q_stat_t q_stat_o
);
  import cbpg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pair_t            entries_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign q_stat_o.full  = (cnt_q == CntW'(Depth));
  assign q_stat_o.empty = (cnt_q == '0);
  assign do_push = push_valid_i && !q_stat_o.full;
  assign do_pop  = pop_i && !q_stat_o.empty;
  assign pop_data_o = entries_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wptr_q] <= push_data_i;
    end
  end

endmodule

[hdl/cbpg_back.sv]
`timescale 1ns / 1ps
module cbpg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbpg_pkg::q_stat_t   q_stat_i,
  input  cbpg_pkg::pair_t     pop_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cbpg_pkg::out_item_t out_data_o
);
  import cbpg_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      have_second_q, have_second_d;
  out_item_t out_q, out_d;
  out_item_t second_q, second_d;
  logic      advance;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o = advance && !have_second_q && !q_stat_i.empty;

  always_comb begin
    out_valid_d   = out_valid_q;
    have_second_d = have_second_q;
    out_d         = out_q;
    second_d      = second_q;
    if (advance) begin
      if (have_second_q) begin
        out_d         = second_q;
        out_valid_d   = 1'b1;
        have_second_d = 1'b0;
      end else if (!q_stat_i.empty) begin
        out_d.out_x            = pop_data_i.x;
        out_d.out_z            = pop_data_i.z;
        out_d.out_height_q8    = pop_data_i.h_first;
        out_d.color            = pop_data_i.col_first;
        out_d.last             = 1'b0;
        second_d.out_x         = pop_data_i.x;
        second_d.out_z         = pop_data_i.z;
        second_d.out_height_q8 = pop_data_i.h_second;
        second_d.color         = pop_data_i.col_second;
        second_d.last          = 1'b1;
        out_valid_d            = 1'b1;
        have_second_d          = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      have_second_q <= 1'b0;
    end else begin
      out_valid_q   <= out_valid_d;
      have_second_q <= have_second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    second_q <= second_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/cloud_billboard_point_generator_core.sv]
`timescale 1ns / 1ps
// an accepted texel goes through the front stage register, then a queue entry, then the output register
// each accepted texel yields two points; the output port emits one point per cycle unless out_stall_i holds it
// a rejected texel is taken at intake and gives no point
// reset: all valid flags and queue pointers cleared, density threshold 170,
// brightness 256, viewer height 0
module cloud_billboard_point_generator_core #(
  parameter int unsigned QDepth = cbpg_pkg::QDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [24:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cbpg_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cbpg_pkg::out_item_t out_data_o
);
  import cbpg_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    push_valid, pop;
  pair_t   push_data, pop_data;
  q_stat_t q_stat;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDensityThreshold: cfg_d.density_threshold = cfg_data_i[7:0];
        CfgBrightness:       cfg_d.brightness        = cfg_data_i[8:0];
        CfgViewerHeight:     cfg_d.viewer_height_q8  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.density_threshold <= ThrReset;
      cfg_q.brightness        <= BrightReset;
      cfg_q.viewer_height_q8  <= ViewerReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cbpg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .q_stat_i     (q_stat)
  );

  cbpg_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .pop_data_o   (pop_data),
    .q_stat_o     (q_stat)
  );

  cbpg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // second point follows a first point transfer at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o && out_data_o.last)
    else $error("second point missing");

  // after a last point the next shown point opens a new pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.last |=> !out_valid_o || !out_data_o.last)
    else $error("last point repeated");

  // intake only stalls on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_stat.full && push_valid)
    else $error("intake stalled without full queue");

endmodule
